// ----- rtl/core/vrd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, tables, types and elaboration-time helpers for the vector rotator.
package vrd_pkg;

	localparam int ITER_DEFAULT = 20;
	localparam int ITER_MAX     = 30;

	localparam int IO_W   = 32;
	localparam int EPS_W  = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	// datapath widths: quadrant-turned input, CORDIC x/y with guard bits, angle residue
	localparam int QW    = 33;
	localparam int XW    = 43;
	localparam int ZW    = 32;
	localparam int GUARD = 8;
	localparam int GAIN_SHIFT = 30 - GUARD;

	// angle reduction: 360 deg in Q16.16 is 45 * 2^19
	localparam logic [5:0]  D45         = 6'd45;
	localparam logic [13:0] ANG_HI_OFS  = 14'd4140;   // 92 * 45, keeps the high part positive
	localparam logic [14:0] RECIP45_V   = 15'd23302;  // ceil(2^20 / 45)
	localparam int          RECIP45_V_SH = 20;
	localparam logic [19:0] RECIP45_W   = 20'd745655; // ceil(2^25 / 45)
	localparam int          RECIP45_W_SH = 25;
	localparam logic [4:0]  W_BIAS      = 5'd22;      // rounding term 180 / 8

	typedef logic [1:0] quad_t;
	localparam quad_t QUAD_0 = 2'd0;
	localparam quad_t QUAD_1 = 2'd1;
	localparam quad_t QUAD_2 = 2'd2;
	localparam quad_t QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 exact;
	} vrd_cell_t;

	localparam logic [31:0] ATAN_TURNS [ITER_MAX] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef logic [31:0] turn_tab_t [45];
	typedef logic [5:0]  rem_tab_t  [45];

	// floor(r * 2^32 / 45) plus the eighth-turn offset used for quadrant selection
	function automatic turn_tab_t build_qtab();
		turn_tab_t   tab;
		logic [63:0] v;
		for (int r = 0; r < 45; r++) begin
			v = ((64'(r)) << 32) / 64'd45 + (64'd1 << 29);
			tab[r] = v[31:0];
		end
		return tab;
	endfunction

	function automatic rem_tab_t build_rtab();
		rem_tab_t    tab;
		logic [63:0] v;
		for (int r = 0; r < 45; r++) begin
			v = ((64'(r)) << 32) % 64'd45;
			tab[r] = v[5:0];
		end
		return tab;
	endfunction

	localparam turn_tab_t QTAB_U = build_qtab();
	localparam rem_tab_t  RTAB   = build_rtab();

	// CORDIC gain correction in Q2.30 for n iterations, rounded reciprocal of sqrt(prod)
	function automatic logic [63:0] gain_q30(input int n);
		logic [63:0] p;
		logic [63:0] rad;
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		p = 64'd1 << 30;
		for (int i = 0; i < ITER_MAX; i++) begin
			if (i < n) p = p + (p >> (2 * i));
		end
		rad = p << 30;
		res = '0;
		for (int k = 0; k < 32; k++) begin
			bitv = 64'd1 << (62 - 2 * k);
			if (rad >= res + bitv) begin
				rad = rad - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		num = (64'd1 << 60) + (res >> 1);
		rem = '0;
		quo = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], num[k]};
			if (rem >= res) begin
				rem = rem - res;
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

endpackage

// ----- rtl/core/vrd_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the vector rotator.
interface vrd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [vrd_pkg::IO_W-1:0]     x_in;
	logic signed [vrd_pkg::IO_W-1:0]     y_in;
	logic signed [vrd_pkg::IO_W-1:0]     angle_deg;

	modport source (output valid, output x_in, output y_in, output angle_deg, input ready);
	modport sink   (input valid, input x_in, input y_in, input angle_deg, output ready);
endinterface

interface vrd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [vrd_pkg::IO_W-1:0]     x_out;
	logic signed [vrd_pkg::IO_W-1:0]     y_out;
	logic                                exact_quarter;

	modport source (output valid, output x_out, output y_out, output exact_quarter, input ready);
	modport sink   (input valid, input x_out, input y_out, input exact_quarter, output ready);
endinterface

// ----- rtl/core/vrd_prep.sv -----
`timescale 1ns / 1ps
// Front end: angle reduction, quarter-turn snap, quadrant turn and gain scaling.
module vrd_prep #(
	parameter int ITERATIONS = vrd_pkg::ITER_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [vrd_pkg::EPS_W-1:0]     snap_eps,
	vrd_in_if.sink                        request,
	output vrd_pkg::vrd_cell_t            cell_d,
	output logic                          cell_vld,
	input  logic                          down_en
);

	localparam int NST = 8;
	localparam logic [63:0] GAIN_FULL = vrd_pkg::gain_q30(ITERATIONS);
	localparam logic signed [vrd_pkg::QW-1:0] GAIN_S = vrd_pkg::QW'(GAIN_FULL);

	logic [NST:1]   vld_q;
	logic [NST+1:1] en;

	always_comb begin
		en[NST+1] = down_en;
		for (int k = NST; k >= 1; k--) en[k] = !vld_q[k] || en[k+1];
	end

	assign request.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= request.valid;
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: input capture
	logic signed [31:0] x_s1, y_s1;
	logic        [31:0] ang_s1;
	// stage 2: reciprocal products for the two mod-45 reductions
	logic signed [31:0] x_s2, y_s2;
	logic [13:0] v_s2;
	logic [18:0] l_s2;
	logic [28:0] pv_s2;
	logic [38:0] pl_s2;
	// stage 3: remainders
	logic signed [31:0] x_s3, y_s3;
	logic [5:0]  r_s3, rl_s3;
	logic [18:0] l_s3;
	logic [13:0] ql_s3;
	// stage 4: snap operand, binary-angle tail
	logic signed [31:0] x_s4, y_s4;
	logic [5:0]  r_s4;
	logic [13:0] ql_s4;
	logic [24:0] t_s4;
	logic [18:0] w_s4;
	// stage 5: snap decision, tail product
	logic signed [31:0] x_s5, y_s5;
	logic [5:0]  r_s5;
	logic [13:0] ql_s5;
	logic [38:0] pw_s5;
	logic        snap_s5;
	vrd_pkg::quad_t sq_s5;
	// stage 6: quadrant and residual angle
	logic signed [31:0] x_s6, y_s6;
	vrd_pkg::quad_t quad_s6;
	logic signed [vrd_pkg::ZW-1:0] z_s6;
	logic        exact_s6;
	// stage 7: turned vector
	logic signed [vrd_pkg::QW-1:0] xr_s7, yr_s7;
	logic signed [vrd_pkg::ZW-1:0] z_s7;
	logic        exact_s7;
	// stage 8: gain products
	logic signed [63:0] px_s8, py_s8;
	logic signed [vrd_pkg::QW-1:0] xr_s8, yr_s8;
	logic signed [vrd_pkg::ZW-1:0] z_s8;
	logic        exact_s8;

	// stage 1 logic
	logic [13:0] v1;
	logic [18:0] l1;
	logic [28:0] pv1;
	logic [38:0] pl1;
	assign v1  = 14'({ang_s1[31], ang_s1[31:19]}) + vrd_pkg::ANG_HI_OFS;
	assign l1  = ang_s1[18:0];
	assign pv1 = 29'(v1) * 29'(vrd_pkg::RECIP45_V);
	assign pl1 = 39'(l1) * 39'(vrd_pkg::RECIP45_W);

	// stage 2 logic
	logic [8:0]  qv2;
	logic [13:0] ql2;
	logic [5:0]  r2, rl2;
	assign qv2 = pv_s2[28:vrd_pkg::RECIP45_V_SH];
	assign ql2 = pl_s2[38:vrd_pkg::RECIP45_W_SH];
	assign r2  = 6'(v_s2 - 14'(qv2) * 14'(vrd_pkg::D45));
	assign rl2 = 6'(l_s2 - 19'(ql2) * 19'(vrd_pkg::D45));

	// stage 3 logic: reduced angle is {r, l}
	logic [24:0] t3;
	logic [18:0] w3;
	assign t3 = {r_s3, l_s3} + 25'(snap_eps);
	assign w3 = {rl_s3, 13'b0} + 19'(vrd_pkg::RTAB[r_s3]) + 19'(vrd_pkg::W_BIAS);

	// stage 4 logic
	logic [38:0] pw4;
	logic [7:0]  hi4;
	logic [2:0]  qs4;
	logic [5:0]  remhi4;
	logic [22:0] rem4;
	logic        hit4;
	vrd_pkg::quad_t sq4;
	assign pw4 = 39'(w_s4) * 39'(vrd_pkg::RECIP45_W);
	assign hi4 = t_s4[24:17];
	always_comb begin
		// t / 90deg with 90deg = 45 * 2^17
		if (hi4 >= 8'd180) begin
			qs4 = 3'd4;
			remhi4 = 6'(hi4 - 8'd180);
		end else if (hi4 >= 8'd135) begin
			qs4 = 3'd3;
			remhi4 = 6'(hi4 - 8'd135);
		end else if (hi4 >= 8'd90) begin
			qs4 = 3'd2;
			remhi4 = 6'(hi4 - 8'd90);
		end else if (hi4 >= 8'(vrd_pkg::D45)) begin
			qs4 = 3'd1;
			remhi4 = 6'(hi4 - 8'(vrd_pkg::D45));
		end else begin
			qs4 = 3'd0;
			remhi4 = 6'(hi4);
		end
	end
	assign rem4 = {remhi4, t_s4[16:0]};
	assign hit4 = rem4 < 23'({snap_eps, 1'b0});
	// snapping just below a full turn lands on quadrant four: treat as zero
	assign sq4  = qs4[2] ? vrd_pkg::QUAD_0 : qs4[1:0];

	// stage 5 logic
	logic [12:0] qw5;
	logic [31:0] u5;
	assign qw5 = 13'(pw_s5[38:vrd_pkg::RECIP45_W_SH]);
	assign u5  = vrd_pkg::QTAB_U[r_s5] + 32'({ql_s5, 13'b0}) + 32'(qw5);

	// stage 6 logic: exact quarter turn
	logic signed [vrd_pkg::QW-1:0] xe6, ye6, xr6, yr6;
	assign xe6 = vrd_pkg::QW'(x_s6);
	assign ye6 = vrd_pkg::QW'(y_s6);
	always_comb begin
		case (quad_s6)
			vrd_pkg::QUAD_1: begin
				xr6 = -ye6;
				yr6 = xe6;
			end
			vrd_pkg::QUAD_2: begin
				xr6 = -xe6;
				yr6 = -ye6;
			end
			vrd_pkg::QUAD_3: begin
				xr6 = ye6;
				yr6 = -xe6;
			end
			default: begin
				xr6 = xe6;
				yr6 = ye6;
			end
		endcase
	end

	// stage 7 logic
	logic signed [63:0] px7, py7;
	assign px7 = xr_s7 * GAIN_S;
	assign py7 = yr_s7 * GAIN_S;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1   <= request.x_in;
			y_s1   <= request.y_in;
			ang_s1 <= request.angle_deg;
		end
		if (en[2]) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			v_s2  <= v1;
			l_s2  <= l1;
			pv_s2 <= pv1;
			pl_s2 <= pl1;
		end
		if (en[3]) begin
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			r_s3  <= r2;
			rl_s3 <= rl2;
			l_s3  <= l_s2;
			ql_s3 <= ql2;
		end
		if (en[4]) begin
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			r_s4  <= r_s3;
			ql_s4 <= ql_s3;
			t_s4  <= t3;
			w_s4  <= w3;
		end
		if (en[5]) begin
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			r_s5    <= r_s4;
			ql_s5   <= ql_s4;
			pw_s5   <= pw4;
			snap_s5 <= hit4;
			sq_s5   <= sq4;
		end
		if (en[6]) begin
			x_s6     <= x_s5;
			y_s6     <= y_s5;
			quad_s6  <= snap_s5 ? sq_s5 : u5[31:30];
			// residual angle in [-1/8, 1/8) turn
			z_s6     <= vrd_pkg::ZW'($signed({~u5[29], u5[28:0]}));
			exact_s6 <= snap_s5;
		end
		if (en[7]) begin
			xr_s7    <= xr6;
			yr_s7    <= yr6;
			z_s7     <= z_s6;
			exact_s7 <= exact_s6;
		end
		if (en[8]) begin
			px_s8    <= px7;
			py_s8    <= py7;
			xr_s8    <= xr_s7;
			yr_s8    <= yr_s7;
			z_s8     <= z_s7;
			exact_s8 <= exact_s7;
		end
	end

	// exact results ride through the cells pre-scaled by the guard bits
	always_comb begin
		cell_d.z     = z_s8;
		cell_d.exact = exact_s8;
		if (exact_s8) begin
			cell_d.x = vrd_pkg::XW'(xr_s8) <<< vrd_pkg::GUARD;
			cell_d.y = vrd_pkg::XW'(yr_s8) <<< vrd_pkg::GUARD;
		end else begin
			cell_d.x = vrd_pkg::XW'(px_s8 >>> vrd_pkg::GAIN_SHIFT);
			cell_d.y = vrd_pkg::XW'(py_s8 >>> vrd_pkg::GAIN_SHIFT);
		end
	end

	assign cell_vld = vld_q[NST];

endmodule

// ----- rtl/core/vrd_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC micro-rotation stage of the cell chain.
module vrd_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vrd_pkg::vrd_cell_t d,
	input  logic               d_vld,
	input  logic               en,
	output vrd_pkg::vrd_cell_t q,
	output logic               q_vld
);

	localparam logic signed [vrd_pkg::ZW-1:0] ATAN_STEP = vrd_pkg::ATAN_TURNS[STEP];

	logic signed [vrd_pkg::XW-1:0] xi, yi, dx, dy;
	logic signed [vrd_pkg::ZW-1:0] zi;
	vrd_pkg::vrd_cell_t nxt;
	vrd_pkg::vrd_cell_t data_q;
	logic vld_q;

	assign xi = d.x;
	assign yi = d.y;
	assign zi = d.z;
	assign dx = yi >>> STEP;
	assign dy = xi >>> STEP;

	always_comb begin
		nxt = d;
		if (!d.exact) begin
			if (!zi[vrd_pkg::ZW-1]) begin
				nxt.x = xi - dx;
				nxt.y = yi + dy;
				nxt.z = zi - ATAN_STEP;
			end else begin
				nxt.x = xi + dx;
				nxt.y = yi - dy;
				nxt.z = zi + ATAN_STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign q     = data_q;
	assign q_vld = vld_q;

endmodule

// ----- rtl/core/vector_rotate_degrees.sv -----
`timescale 1ns / 1ps
// Top level of the fixed-point vector rotator (angle in degrees, CORDIC cell chain).
//
// Usage:
//  - request: valid/ready channel carrying x_in, y_in (signed Q16.16) and angle_deg
//    (signed Q16.16 degrees, counterclockwise). A request is taken on a clock edge
//    where valid and ready are both high.
//  - result: valid/ready channel carrying x_out, y_out (saturated Q16.16) and
//    exact_quarter, set when the angle snapped to a multiple of 90 degrees.
//  - cfg_we/cfg_wdata write snap_epsilon (unsigned Q0.16 degrees); write only while idle.
//  - Throughput: one request per clock while ready is high. Every stage is a
//    register with its own valid bit, so empty slots collapse and ready stays
//    high while any slot is free.
//  - Pipeline: 8 front-end stages (angle reduction by reciprocal multiplies, snap
//    test, quadrant turn, gain multiply), then ITERATIONS CORDIC cells, then the
//    output register that drives result valid.
//  - Receiver stall: the output register holds its result; upstream stages keep
//    filling until the chain is full, then ready drops.
//  - Reset (arst_n low): all valid bits clear, snap_epsilon returns to 1.
module vector_rotate_degrees #(
	parameter int ITERATIONS = vrd_pkg::ITER_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [vrd_pkg::EPS_W-1:0] cfg_wdata,
	vrd_in_if.sink                    request,
	vrd_out_if.source                 result
);

	localparam logic signed [vrd_pkg::XW-1:0] OUT_MAX = vrd_pkg::XW'(64'sh7FFF_FFFF);
	localparam logic signed [vrd_pkg::XW-1:0] OUT_MIN = vrd_pkg::XW'(-64'sd2147483648);

	// snap tolerance register
	logic [vrd_pkg::EPS_W-1:0] snap_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_eps_q <= vrd_pkg::EPS_RESET;
		end else if (cfg_we) begin
			snap_eps_q <= cfg_wdata;
		end
	end

	// chain taps: index 0 is the front-end output, index ITERATIONS the last cell
	vrd_pkg::vrd_cell_t    cell_d [ITERATIONS+1];
	logic [ITERATIONS:0]   cell_vld;
	logic [ITERATIONS:0]   cell_en;
	logic                  out_vld_q;
	logic                  out_en;

	vrd_prep #(
		.ITERATIONS (ITERATIONS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap_eps (snap_eps_q),
		.request  (request),
		.cell_d   (cell_d[0]),
		.cell_vld (cell_vld[0]),
		.down_en  (cell_en[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		vrd_cell #(
			.STEP (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (cell_d[i]),
			.d_vld  (cell_vld[i]),
			.en     (cell_en[i]),
			.q      (cell_d[i+1]),
			.q_vld  (cell_vld[i+1])
		);
	end

	// a stage loads when it is empty or its successor loads
	assign out_en = !out_vld_q || result.ready;
	always_comb begin
		cell_en[ITERATIONS] = out_en;
		for (int i = ITERATIONS - 1; i >= 0; i--) cell_en[i] = !cell_vld[i+1] || cell_en[i+1];
	end

	// drop guard bits (floor) and clamp to 32 bits
	logic signed [vrd_pkg::XW-1:0] xs, ys;
	logic signed [vrd_pkg::IO_W-1:0] xsat, ysat;
	assign xs = cell_d[ITERATIONS].x >>> vrd_pkg::GUARD;
	assign ys = cell_d[ITERATIONS].y >>> vrd_pkg::GUARD;

	always_comb begin
		if (xs > OUT_MAX)      xsat = vrd_pkg::IO_W'(OUT_MAX);
		else if (xs < OUT_MIN) xsat = vrd_pkg::IO_W'(OUT_MIN);
		else                   xsat = vrd_pkg::IO_W'(xs);
		if (ys > OUT_MAX)      ysat = vrd_pkg::IO_W'(OUT_MAX);
		else if (ys < OUT_MIN) ysat = vrd_pkg::IO_W'(OUT_MIN);
		else                   ysat = vrd_pkg::IO_W'(ys);
	end

	logic signed [vrd_pkg::IO_W-1:0] x_out_q, y_out_q;
	logic exact_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_en) begin
			out_vld_q <= cell_vld[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			x_out_q <= xsat;
			y_out_q <= ysat;
			exact_q <= cell_d[ITERATIONS].exact;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.x_out         = x_out_q;
	assign result.y_out         = y_out_q;
	assign result.exact_quarter = exact_q;

	// any free slot downstream of the front end must leave request ready high
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_vld_q || !(&cell_vld[ITERATIONS:1])) |-> request.ready)
		else $error("request stalled with a free slot in the chain");

	// a result only appears when the last cell held a request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cell_vld[ITERATIONS]))
		else $error("result appeared without a request in the last cell");

	// exact quarter-turn requests pass the cells untouched
	a_exact_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_vld[ITERATIONS] && cell_d[ITERATIONS].exact) |->
		(cell_d[ITERATIONS].x[vrd_pkg::GUARD-1:0] == '0 &&
		 cell_d[ITERATIONS].y[vrd_pkg::GUARD-1:0] == '0))
		else $error("exact request modified by a CORDIC cell");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vector_rotate_degrees: directed rows, then random requests.
module testbench;

	localparam int     ITER         = 20;
	localparam int     LATENCY      = ITER + 8;
	localparam int     RANDOM_ITEMS = 1750;
	localparam int     PHASES       = 6;
	localparam int     N_DIRECTED   = 25;
	localparam int     HOLD_CYCLES  = 160;
	localparam longint CYCLE_LIMIT  = 500000;
	localparam int     SCALE_SHIFT  = 22;
	localparam int     GUARD_BITS   = 8;

	localparam longint FULL_TURN    = 23592960;
	localparam longint QUARTER_TURN = 5898240;

	localparam logic signed [31:0] ONE     = 32'sh0001_0000;
	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
	localparam logic signed [31:0] A45     = 32'sd2949120;
	localparam logic signed [31:0] A90     = 32'sd5898240;
	localparam logic signed [31:0] A180    = 32'sd11796480;
	localparam logic signed [31:0] A270    = 32'sd17694720;
	localparam logic signed [31:0] A360    = 32'sd23592960;

	// arctan(2^-i) in binary angle units, full turn = 2^32
	localparam logic [31:0] ARCTAN [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               exact;
	} vec_result_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] ang;
		logic               known;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic               eq;
	} stim_row_t;

	// x, y, angle, result typed in?, expected x, expected y, exact
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ONE,     0,       0,           1, ONE,      0,        1},
		'{ONE,     0,       A90,         1, 0,        ONE,      1},
		'{ONE,     2*ONE,   A180,        1, -ONE,     -2*ONE,   1},
		'{ONE,     2*ONE,   A270,        1, 2*ONE,    -ONE,     1},
		'{ONE,     2*ONE,   -A90,        1, 2*ONE,    -ONE,     1},
		'{ONE,     2*ONE,   A360,        1, ONE,      2*ONE,    1},
		'{ONE,     2*ONE,   A360 - 1,    1, ONE,      2*ONE,    1},
		'{ONE,     2*ONE,   A90 - 1,     1, -2*ONE,   ONE,      1},
		'{ONE,     2*ONE,   A90 + 1,     0, 0,        0,        0},
		'{ONE,     2*ONE,   -A360 - 1,   1, ONE,      2*ONE,    1},
		'{NEG_MAX, 0,       A180,        1, POS_MAX,  0,        1},
		'{0,       NEG_MAX, A90,         1, POS_MAX,  0,        1},
		'{NEG_MAX, NEG_MAX, A270,        1, NEG_MAX,  POS_MAX,  1},
		'{POS_MAX, POS_MAX, 0,           1, POS_MAX,  POS_MAX,  1},
		'{POS_MAX, POS_MAX, A45,         0, 0,        0,        0},
		'{NEG_MAX, NEG_MAX, A45,         0, 0,        0,        0},
		'{POS_MAX, NEG_MAX, POS_MAX,     0, 0,        0,        0},
		'{NEG_MAX, POS_MAX, NEG_MAX,     0, 0,        0,        0},
		'{ONE,     0,       32'sd1966080, 0, 0,       0,        0},
		'{0,       ONE,     -32'sd1966080, 0, 0,      0,        0},
		'{ONE,     ONE,     A90 + A45,   0, 0,        0,        0},
		'{-ONE,    ONE,     A180 + A45 + 12345, 0, 0, 0,        0},
		'{ONE,     0,       A270 + A45,  0, 0,        0,        0},
		'{0,       0,       32'sd123456, 0, 0,        0,        0},
		'{-1,      -1,      32'sd1000000, 0, 0,       0,        0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [vrd_pkg::EPS_W-1:0]  cfg_wdata;

	vrd_in_if  req_if ();
	vrd_out_if res_if ();

	vector_rotate_degrees #(.ITERATIONS(ITER)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (req_if),
		.result    (res_if)
	);

	vec_result_t                expected_vectors [$];
	int                         fail_count   = 0;
	int                         results_seen = 0;
	longint                     gain_k;
	logic [vrd_pkg::EPS_W-1:0]  eps_now;
	bit                         rx_holding = 1'b0;
	bit                         tx_burst   = 1'b0;
	bit                         rx_burst   = 1'b0;
	longint                     cycle_count;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > longint'(POS_MAX)) return POS_MAX;
		if (v < longint'(NEG_MAX)) return NEG_MAX;
		return v[31:0];
	endfunction

	function automatic void turn_quadrant(input vrd_pkg::quad_t q, inout longint xv,
			inout longint yv);
		longint tmp;
		case (q)
			vrd_pkg::QUAD_1: begin
				tmp = -yv; yv = xv; xv = tmp;
			end
			vrd_pkg::QUAD_2: begin
				xv = -xv; yv = -yv;
			end
			vrd_pkg::QUAD_3: begin
				tmp = yv; yv = -xv; xv = tmp;
			end
			default: ;
		endcase
	endfunction

	// 1 / prod sqrt(1 + 2^-2i) in Q2.30, rounded
	function automatic longint cordic_gain(input int n);
		longint unsigned prod, rad, root, probe;
		prod = 64'd1 << 30;
		for (int i = 0; i < n; i++) prod += prod >> (2 * i);
		rad   = prod << 30;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > rad) probe >>= 2;
		while (probe != 0) begin
			if (rad >= root + probe) begin
				rad  = rad - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe >>= 2;
		end
		return longint'(((64'd1 << 60) + root / 2) / root);
	endfunction

	function automatic vec_result_t rotate_vector(input logic signed [31:0] xi,
			input logic signed [31:0] yi, input logic signed [31:0] ai,
			input logic [vrd_pkg::EPS_W-1:0] eps);
		vec_result_t     r;
		longint          x, y, a, e, biased, z, dx, dy;
		longint unsigned b, u;
		longint          qi;
		vrd_pkg::quad_t  q;
		x = xi;
		y = yi;
		e = eps;
		a = longint'(ai) % FULL_TURN;
		if (a < 0) a += FULL_TURN;

		// near a multiple of 90 degrees: exact swap/negate, no CORDIC
		biased = a + e;
		if ((biased % QUARTER_TURN) < 2 * e) begin
			qi = biased / QUARTER_TURN;
			q  = (qi >= 4) ? vrd_pkg::QUAD_0 : vrd_pkg::quad_t'(qi);
			turn_quadrant(q, x, y);
			r.x     = clamp32(x);
			r.y     = clamp32(y);
			r.exact = 1'b1;
			return r;
		end

		b = (($unsigned(a) << 16) + 64'd180) / 64'd360;
		b = b & 64'hFFFF_FFFF;
		u = (b + 64'h2000_0000) & 64'hFFFF_FFFF;
		q = vrd_pkg::quad_t'(u >> 30);
		z = $signed(u & 64'h3FFF_FFFF) - 64'sh2000_0000;
		turn_quadrant(q, x, y);

		x = (x * gain_k) >>> SCALE_SHIFT;
		y = (y * gain_k) >>> SCALE_SHIFT;
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ARCTAN[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ARCTAN[i]);
			end
		end
		r.x     = clamp32(x >>> GUARD_BITS);
		r.y     = clamp32(y >>> GUARD_BITS);
		r.exact = 1'b0;
		return r;
	endfunction

	function automatic logic signed [31:0] draw_coord();
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return 0;
			3: return -1;
			4, 5, 6: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return $urandom();
		endcase
	endfunction

	// four draws in ten land around the snap windows, so both sides of each edge get hit
	function automatic logic signed [31:0] draw_angle(input logic [vrd_pkg::EPS_W-1:0] eps);
		longint k, off, a, e;
		e = eps;
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return NEG_MAX;
			2, 3, 4, 5: begin
				k   = longint'($urandom_range(0, 728)) - 364;
				off = longint'($urandom_range(0, 32'(2 * e + 6))) - (e + 3);
				a   = k * QUARTER_TURN + off;
				return a[31:0];
			end
			6: return 32'(int'($urandom_range(0, 47185920)) - 23592960);
			default: return $urandom();
		endcase
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("mismatch: %s", msg);
	endtask

	task automatic send_request(input logic signed [31:0] xv, input logic signed [31:0] yv,
			input logic signed [31:0] av, input bit known, input vec_result_t known_res);
		int gap;
		req_if.valid     <= 1'b1;
		req_if.x_in      <= xv;
		req_if.y_in      <= yv;
		req_if.angle_deg <= av;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (known) expected_vectors.push_back(known_res);
		else expected_vectors.push_back(rotate_vector(xv, yv, av, eps_now));
		gap = (tx_burst || rx_holding) ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain: every request answered, then let the pipe settle
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (expected_vectors.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [vrd_pkg::EPS_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		eps_now = v;
	endtask

	initial begin
		logic [vrd_pkg::EPS_W-1:0] eps_plan [PHASES];
		vec_result_t               known_res;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		req_if.valid     = 1'b0;
		req_if.x_in      = '0;
		req_if.y_in      = '0;
		req_if.angle_deg = '0;
		gain_k  = cordic_gain(ITER);
		eps_now = 16'd1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < N_DIRECTED; row++) begin
			known_res = '{DIRECTED_ROWS[row].ex, DIRECTED_ROWS[row].ey, DIRECTED_ROWS[row].eq};
			send_request(DIRECTED_ROWS[row].x, DIRECTED_ROWS[row].y, DIRECTED_ROWS[row].ang,
				DIRECTED_ROWS[row].known, known_res);
		end

		// phase 0 runs at the reset tolerance; the rest rewrite it
		eps_plan = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1,
			16'($urandom_range(2, 300))};
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) write_epsilon(eps_plan[p]);
			repeat (RANDOM_ITEMS / PHASES)
				send_request(draw_coord(), draw_coord(), draw_angle(eps_now), 1'b0, '0);
		end

		wait_idle();
		if (fail_count == 0 && expected_vectors.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// result side: random stalls, plus long hold-offs that back up the whole chain
	initial begin
		vec_result_t seen, want;
		int          stall;
		int          next_hold;
		next_hold    = 500;
		res_if.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (results_seen >= next_hold) begin
				next_hold += 800;
				rx_holding = 1'b1;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);

			seen = '{res_if.x_out, res_if.y_out, res_if.exact_quarter};
			results_seen++;
			if (expected_vectors.size() == 0) begin
				note_failure($sformatf("result with nothing pending: x=%0d y=%0d exact=%0b",
					seen.x, seen.y, seen.exact));
			end else begin
				want = expected_vectors.pop_front();
				if (seen !== want)
					note_failure($sformatf(
						"result %0d: expected x=%0d y=%0d exact=%0b, got x=%0d y=%0d exact=%0b",
						results_seen, want.x, want.y, want.exact, seen.x, seen.y, seen.exact));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
